// ----- design/sjte_pkg.sv -----
// Shared types, constants and the kanji code mapping for the Shift-JIS to
// JIS / EUC-JP converter. Used by sjte_encoder and sjis_to_jis_euc_converter.
package sjte_pkg;

    localparam int unsigned MAX_OUT = 4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_EUC_MODE      = 3'd0,
        REG_SHIFT_IN_SEQ  = 3'd1,
        REG_SHIFT_IN_LEN  = 3'd2,
        REG_SHIFT_OUT_SEQ = 3'd3,
        REG_SHIFT_OUT_LEN = 3'd4
    } t_reg_idx;

    localparam logic [23:0] SHIFT_IN_SEQ_RST  = 24'h1B2440;
    localparam logic [1:0]  SHIFT_IN_LEN_RST  = 2'd3;
    localparam logic [23:0] SHIFT_OUT_SEQ_RST = 24'h1B284A;
    localparam logic [1:0]  SHIFT_OUT_LEN_RST = 2'd3;

    typedef struct packed {
        logic        euc_mode;
        logic [23:0] shift_in_seq;
        logic [1:0]  shift_in_len;
        logic [23:0] shift_out_seq;
        logic [1:0]  shift_out_len;
    } t_cfg;

    typedef struct packed {
        logic       kanji_active;
        logic       trail_expected;
        logic [7:0] held_lead;
    } t_conv_state;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              count;
    } t_result;

    function automatic logic is_lead(input logic [7:0] c);
        return ((c >= 8'h80) && (c <= 8'h9F)) || ((c >= 8'hE0) && (c <= 8'hEF));
    endfunction

    // Maps a lead/trail pair to the JIS row and cell bytes {row, cell}, with bit 7 set on both for EUC.
    function automatic logic [15:0] kanji_code(input logic [7:0] lead,
                                               input logic [7:0] trail,
                                               input logic       euc);
        logic [7:0] ub;
        logic [7:0] lb;
        if (lead <= 8'h9F) begin
            ub = lead - 8'h80;
        end else begin
            ub = (lead & 8'h7F) - 8'h40;
        end
        ub = {ub[6:0], 1'b0};
        if (trail < 8'h9F) begin
            lb = trail - 8'h3F - {7'd0, (trail > 8'h7E)};
            ub = ub - 8'd1;
        end else begin
            lb = trail - 8'h9E;
        end
        ub = ub + 8'h20;
        lb = lb + 8'h20;
        if (euc) begin
            ub = ub | 8'h80;
            lb = lb | 8'h80;
        end
        return {ub, lb};
    endfunction

endpackage

// ----- design/sjte_encoder.sv -----
// Combinational conversion of one Shift-JIS byte into its list of output
// bytes and the next converter state. Depends on sjte_pkg.
module sjte_encoder (
    input  logic [7:0]           i_byte,
    input  sjte_pkg::t_cfg       i_cfg,
    input  sjte_pkg::t_conv_state i_state,
    output sjte_pkg::t_result    o_result,
    output sjte_pkg::t_conv_state o_state
);
    import sjte_pkg::*;

    logic [15:0] code;

    assign code = kanji_code(i_state.held_lead, i_byte, i_cfg.euc_mode);

    always_comb begin
        o_result = '0;
        o_state  = i_state;
        if (i_state.trail_expected) begin
            o_result.bytes[0]      = code[15:8];
            o_result.bytes[1]      = code[7:0];
            o_result.count         = 3'd2;
            o_state.trail_expected = 1'b0;
        end else if (is_lead(i_byte)) begin
            if (!i_cfg.euc_mode && !i_state.kanji_active) begin
                o_result.bytes[0]    = i_cfg.shift_in_seq[23:16];
                o_result.bytes[1]    = i_cfg.shift_in_seq[15:8];
                o_result.bytes[2]    = i_cfg.shift_in_seq[7:0];
                o_result.count       = {1'b0, i_cfg.shift_in_len};
                o_state.kanji_active = 1'b1;
            end
            o_state.held_lead      = i_byte;
            o_state.trail_expected = 1'b1;
        end else begin
            if (!i_cfg.euc_mode && i_state.kanji_active) begin
                // The byte itself follows however many shift-out bytes are used.
                o_result.bytes[0]                   = i_cfg.shift_out_seq[23:16];
                o_result.bytes[1]                   = i_cfg.shift_out_seq[15:8];
                o_result.bytes[2]                   = i_cfg.shift_out_seq[7:0];
                o_result.bytes[i_cfg.shift_out_len] = i_byte;
                o_result.count       = {1'b0, i_cfg.shift_out_len} + 3'd1;
                o_state.kanji_active = 1'b0;
            end else begin
                o_result.bytes[0] = i_byte;
                o_result.count    = 3'd1;
            end
        end
    end

endmodule

// ----- design/sjis_to_jis_euc_converter.sv -----
// Shift-JIS to JIS (ISO-2022-JP style) / EUC-JP byte stream converter, top level.
// Depends on sjte_pkg and sjte_encoder.
//
// Each accepted input byte is registered, converted combinationally and loaded
// into a four-byte result buffer that drains one byte per cycle on the master
// stream while i_m_tready is high; o_m_tlast marks the final byte caused by an
// input byte. An input byte thus yields 0 to 4 output bytes: 0 to 3 for a lead
// byte, which carries the shift-in sequence when kanji mode starts, 2 for the
// trail byte of a kanji, up to 4 for a single byte preceded by a shift-out
// sequence. The result buffer drain sets the sustained rate; a new byte is
// taken in the same cycle the previous result's last byte leaves.
module sjis_to_jis_euc_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: [7:0] in_byte.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // Output stream. tdata: [7:0] out_byte. tlast: last_of_run.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    // Configuration write port.
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_wdata
);
    import sjte_pkg::*;

    t_cfg        r_cfg;
    t_conv_state r_state;
    t_conv_state n_state;
    t_result     n_result;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    logic [MAX_OUT-1:0][7:0] r_bytes;
    logic [1:0]  r_idx;
    logic [2:0]  r_left;

    logic take;
    logic buf_free;
    logic proc_fire;

    assign take       = o_m_tvalid && i_m_tready;
    assign buf_free   = (r_left == 3'd0) || ((r_left == 3'd1) && take);
    assign proc_fire  = r_in_valid && buf_free;
    assign o_s_tready = !r_in_valid || proc_fire;

    assign o_m_tvalid = (r_left != 3'd0);
    assign o_m_tdata  = r_bytes[r_idx];
    assign o_m_tlast  = (r_left == 3'd1);

    sjte_encoder u_encoder (
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_result),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.euc_mode      <= 1'b0;
            r_cfg.shift_in_seq  <= SHIFT_IN_SEQ_RST;
            r_cfg.shift_in_len  <= SHIFT_IN_LEN_RST;
            r_cfg.shift_out_seq <= SHIFT_OUT_SEQ_RST;
            r_cfg.shift_out_len <= SHIFT_OUT_LEN_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_EUC_MODE:      r_cfg.euc_mode      <= i_cfg_wdata[0];
                REG_SHIFT_IN_SEQ:  r_cfg.shift_in_seq  <= i_cfg_wdata;
                REG_SHIFT_IN_LEN:  r_cfg.shift_in_len  <= i_cfg_wdata[1:0];
                REG_SHIFT_OUT_SEQ: r_cfg.shift_out_seq <= i_cfg_wdata;
                REG_SHIFT_OUT_LEN: r_cfg.shift_out_len <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_idx      <= 2'd0;
            r_left     <= 3'd0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (proc_fire) begin
                r_state <= n_state;
                r_idx   <= 2'd0;
                r_left  <= n_result.count;
            end else if (take) begin
                r_idx  <= r_idx + 2'd1;
                r_left <= r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (proc_fire) begin
            r_bytes <= n_result.bytes;
        end
    end

`ifndef NO_ASSERTIONS
    // A kanji transaction always loads exactly two result bytes.
    a_trail_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_state.trail_expected) |=> (r_left == 3'd2))
        else $error("trail byte did not load two result bytes");

    // EUC output never carries shift sequences.
    a_euc_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_cfg.euc_mode) |=> (r_left <= 3'd2))
        else $error("EUC result longer than two bytes");

    // Once the final byte leaves and nothing new is loaded, the output goes idle.
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && o_m_tlast && !proc_fire) |=> !o_m_tvalid)
        else $error("output still valid after last byte with nothing loaded");
`endif

endmodule
